@@ rtl/srd_pkg.sv @@
// Shared types and constants for the serial reply deframer.
package srd_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned KindW = 3;
    localparam int unsigned CfgIdxW = 2;

    typedef logic [ByteW-1:0] byte_t;

    // Register indexes on the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        CFG_PREFIX = 2'd0,
        CFG_OP_A   = 2'd1,
        CFG_OP_B   = 2'd2
    } cfg_idx_t;

    // Result item kinds
    typedef enum logic [KindW-1:0] {
        KIND_BODY  = 3'd0,
        KIND_GOOD  = 3'd1,
        KIND_CSUM  = 3'd2,
        KIND_OPREJ = 3'd3,
        KIND_SHORT = 3'd4
    } kind_t;

    localparam byte_t PrefixReset = 8'hAA;
    localparam byte_t OpAReset    = 8'h08;
    localparam byte_t OpBReset    = 8'h01;

    typedef struct packed {
        byte_t prefix;
        byte_t op_a;
        byte_t op_b;
    } cfg_t;

    typedef struct packed {
        kind_t kind;
        byte_t opcode;
        byte_t body;
        byte_t device;
    } result_t;

endpackage

@@ rtl/srd_cfg_regs.sv @@
// Configuration registers: prefix byte and the two accepted opcodes.
module srd_cfg_regs (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [1:0]              cfg_index,
    input  srd_pkg::byte_t          cfg_data,
    output srd_pkg::cfg_t           cfg
);
    import srd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prefix <= PrefixReset;
            cfg_reg.op_a   <= OpAReset;
            cfg_reg.op_b   <= OpBReset;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PREFIX: cfg_reg.prefix <= cfg_data;
                CFG_OP_A:   cfg_reg.op_a   <= cfg_data;
                CFG_OP_B:   cfg_reg.op_b   <= cfg_data;
                default:    ;  // unused index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/srd_fsm.sv @@
// Per-byte packet state machine: prefix hunt, header, body, checksum.
module srd_fsm (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_fire,
    input  srd_pkg::byte_t          rx_byte,
    input  srd_pkg::cfg_t           cfg,
    output logic                    res_valid,
    output srd_pkg::result_t        res
);
    import srd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT1  = 3'd0,
        PH_HUNT2  = 3'd1,
        PH_OPCODE = 3'd2,
        PH_LENGTH = 3'd3,
        PH_BODY   = 3'd4,
        PH_DEVICE = 3'd5,
        PH_CHECK  = 3'd6
    } phase_t;

    phase_t phase_reg, phase_next;
    byte_t  sum_reg, sum_next;
    byte_t  opcode_reg, opcode_next;
    byte_t  left_reg, left_next;
    byte_t  device_reg, device_next;

    always_comb
    begin
        phase_next  = phase_reg;
        sum_next    = sum_reg;
        opcode_next = opcode_reg;
        left_next   = left_reg;
        device_next = device_reg;
        res_valid   = 1'b0;
        res.kind    = KIND_BODY;
        res.opcode  = opcode_reg;
        res.body    = '0;
        res.device  = '0;

        if (in_fire)
        begin
            unique case (phase_reg)
                PH_HUNT2:
                begin
                    phase_next = (rx_byte == cfg.prefix) ? PH_OPCODE : PH_HUNT1;
                end
                PH_OPCODE:
                begin
                    opcode_next = rx_byte;
                    if (rx_byte != cfg.op_a && rx_byte != cfg.op_b)
                    begin
                        phase_next = PH_HUNT1;
                        res_valid  = 1'b1;
                        res.kind   = KIND_OPREJ;
                        res.opcode = rx_byte;
                    end
                    else
                    begin
                        sum_next   = rx_byte;
                        phase_next = PH_LENGTH;
                    end
                end
                PH_LENGTH:
                begin
                    if (rx_byte < byte_t'(2))
                    begin
                        phase_next = PH_HUNT1;
                        res_valid  = 1'b1;
                        res.kind   = KIND_SHORT;
                    end
                    else
                    begin
                        sum_next   = sum_reg + rx_byte;
                        left_next  = rx_byte - byte_t'(2);
                        // length of two means no body at all
                        phase_next = (rx_byte == byte_t'(2)) ? PH_DEVICE : PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    sum_next  = sum_reg + rx_byte;
                    left_next = left_reg - byte_t'(1);
                    if (left_reg == byte_t'(1))
                        phase_next = PH_DEVICE;
                    res_valid = 1'b1;
                    res.kind  = KIND_BODY;
                    res.body  = rx_byte;
                end
                PH_DEVICE:
                begin
                    sum_next    = sum_reg + rx_byte;
                    device_next = rx_byte;
                    phase_next  = PH_CHECK;
                end
                PH_CHECK:
                begin
                    phase_next = PH_HUNT1;
                    res_valid  = 1'b1;
                    if (rx_byte == sum_reg)
                    begin
                        res.kind   = KIND_GOOD;
                        res.device = device_reg;
                    end
                    else
                    begin
                        res.kind = KIND_CSUM;
                    end
                end
                default:
                begin
                    phase_next = (rx_byte == cfg.prefix) ? PH_HUNT2 : PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT1;
            sum_reg    <= '0;
            opcode_reg <= '0;
            left_reg   <= '0;
            device_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            sum_reg    <= sum_next;
            opcode_reg <= opcode_next;
            left_reg   <= left_next;
            device_reg <= device_next;
        end
    end

    a_res_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> in_fire)
        else $error("result without an accepted byte");

    a_body_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> left_reg != '0)
        else $error("body phase with no bytes left");

    // checksum phase waits in place until its byte arrives
    a_good_after_device: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CHECK |->
            ($past(phase_reg) == PH_DEVICE || $past(phase_reg) == PH_CHECK))
        else $error("checksum phase not entered from device phase");

endmodule

@@ rtl/srd_out_skid.sv @@
// Result register with a one-entry skid stage toward the output channel.
module srd_out_skid (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  srd_pkg::result_t        push_data,
    input  logic                    out_stall,
    output logic                    out_valid,
    output srd_pkg::result_t        out_data,
    output logic                    full
);
    import srd_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // input side is stalled here, so no push to handle
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign full      = skid_valid_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result pushed into a full skid stage");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pop |=> !skid_valid_reg && out_valid_reg)
        else $error("skid entry lost on drain");

endmodule

@@ rtl/serial_reply_deframer.sv @@
// Serial reply deframer top level: config registers, packet FSM, output skid.
//
//  channel   signals                                           direction
//  input     in_valid, in_stall, rx_byte                       bytes in
//  output    out_valid, out_stall, item_kind, packet_opcode,   results out
//            body_byte, device_number
//  config    cfg_write, cfg_index, cfg_data                    writes in
//
// One byte per cycle is taken while in_stall is low; the FSM updates its state
// and forms at most one result, registered at the same edge that takes the byte.
// A two-entry output (register plus skid) absorbs one more result while the
// output stalls; in_stall rises only when the skid entry is occupied.
// rst_n clears the phase to prefix hunt and restores register defaults.
module serial_reply_deframer (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              rx_byte,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              item_kind,
    output logic [7:0]              packet_opcode,
    output logic [7:0]              body_byte,
    output logic [7:0]              device_number,
    input  logic                    cfg_write,
    input  logic [1:0]              cfg_index,
    input  logic [7:0]              cfg_data
);
    import srd_pkg::*;

    cfg_t    cfg;
    logic    in_fire;
    logic    res_valid;
    result_t res;
    result_t out_data;
    logic    full;

    assign in_stall = full;
    assign in_fire  = in_valid && !full;

    srd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srd_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .rx_byte   (rx_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    srd_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .full      (full)
    );

    assign item_kind     = out_data.kind;
    assign packet_opcode = out_data.opcode;
    assign body_byte     = out_data.body;
    assign device_number = out_data.device;

endmodule
